// ===== rtl/atsk_pkg.sv =====
// ----------------------------------------------------------------------------
// atsk_pkg - shared types and constants of the scan code decoder
// Event codes, prefix and control bytes, the decoder-to-sequencer command
// word and the fixed scan index to keycode table.
// ----------------------------------------------------------------------------
`default_nettype none

package atsk_pkg;

	// Keycode space and derived index width of the pressed-key map
	localparam int KEYCODE_SPACE = 256;
	localparam int KEY_W         = $clog2(KEYCODE_SPACE);

	// Depth of the command queue between decoder and sequencer
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Event kinds
	localparam logic [1:0] KIND_SCAN = 2'd0;
	localparam logic [1:0] KIND_KEY  = 2'd1;
	localparam logic [1:0] KIND_SYNC = 2'd2;

	// Key event values
	localparam logic [1:0] VAL_RELEASE = 2'd0;
	localparam logic [1:0] VAL_PRESS   = 2'd1;
	localparam logic [1:0] VAL_REPEAT  = 2'd2;

	// Prefix and control bytes
	localparam logic [7:0] BYTE_E0 = 8'he0;
	localparam logic [7:0] BYTE_E1 = 8'he1;
	localparam logic [7:0] BYTE_AA = 8'haa;
	localparam logic [7:0] BYTE_F0 = 8'hf0;
	localparam logic [7:0] BYTE_FA = 8'hfa;
	localparam logic [7:0] BYTE_FE = 8'hfe;
	localparam logic [7:0] BYTE_FF = 8'hff;
	localparam logic [7:0] BYTE_F1 = 8'hf1;
	localparam logic [7:0] BYTE_F2 = 8'hf2;

	// Ambiguous bytes, in flag order
	localparam int NUM_AMB = 6;
	localparam logic [7:0] AMB_BYTES [NUM_AMB] = '{
		BYTE_AA, BYTE_FF, BYTE_FA, BYTE_FE, BYTE_F1, BYTE_F2
	};

	// Table codes and special scan indexes
	localparam logic [7:0] ROM_UNKNOWN = 8'd0;
	localparam logic [7:0] ROM_IGNORE  = 8'd255;
	localparam logic [8:0] IDX_HANJA   = 9'h171;
	localparam logic [8:0] IDX_HANGEUL = 9'h172;

	// Prefix depth values
	localparam logic [1:0] PFX_NONE = 2'd0;
	localparam logic [1:0] PFX_E0   = 2'd1;
	localparam logic [1:0] PFX_E1   = 2'd2;

	// Decoded key word passed from decoder to sequencer
	typedef struct packed {
		logic [8:0]       idx;
		logic [KEY_W-1:0] key;
		logic             rel;
	} cmd_t;

	// Sequencer steps
	typedef enum logic [2:0] {
		ST_SCAN,
		ST_KEY,
		ST_SYNC,
		ST_SCAN2,
		ST_KEY2,
		ST_SYNC2
	} step_t;

	// Scan index to keycode; low indexes 1..83 map to themselves
	function automatic logic [7:0] rom_lookup(input logic [8:0] idx);
		logic [7:0] k;
		k = ROM_UNKNOWN;
		if (idx[8]) begin
			if (idx == IDX_HANJA)
				k = 8'd123;
			else if (idx == IDX_HANGEUL)
				k = 8'd122;
		end else if (idx[7:0] >= 8'd1 && idx[7:0] <= 8'd83) begin
			k = idx[7:0];
		end else begin
			case (idx[7:0])
				8'd84:  k = 8'd99;
				8'd86:  k = 8'd86;
				8'd87:  k = 8'd87;
				8'd88:  k = 8'd88;
				8'd89:  k = 8'd117;
				8'd92:  k = 8'd95;
				8'd93:  k = 8'd183;
				8'd94:  k = 8'd184;
				8'd95:  k = 8'd185;
				8'd112: k = 8'd93;
				8'd115: k = 8'd89;
				8'd118: k = 8'd85;
				8'd119: k = 8'd91;
				8'd120: k = 8'd90;
				8'd121: k = 8'd92;
				8'd123: k = 8'd94;
				8'd125: k = 8'd124;
				8'd126: k = 8'd121;
				8'd144: k = 8'd165;
				8'd153: k = 8'd163;
				8'd156: k = 8'd96;
				8'd157: k = 8'd97;
				8'd160: k = 8'd113;
				8'd161: k = 8'd140;
				8'd162: k = 8'd164;
				8'd164: k = 8'd166;
				8'd170: k = ROM_IGNORE;
				8'd174: k = 8'd114;
				8'd176: k = 8'd115;
				8'd178: k = 8'd172;
				8'd181: k = 8'd98;
				8'd182: k = ROM_IGNORE;
				8'd183: k = 8'd99;
				8'd184: k = 8'd100;
				8'd197: k = 8'd119;
				8'd198: k = 8'd119;
				8'd199: k = 8'd102;
				8'd200: k = 8'd103;
				8'd201: k = 8'd104;
				8'd203: k = 8'd105;
				8'd204: k = 8'd112;
				8'd205: k = 8'd106;
				8'd206: k = 8'd118;
				8'd207: k = 8'd107;
				8'd208: k = 8'd108;
				8'd209: k = 8'd109;
				8'd210: k = 8'd110;
				8'd211: k = 8'd111;
				8'd219: k = 8'd125;
				8'd220: k = 8'd126;
				8'd221: k = 8'd127;
				8'd222: k = 8'd116;
				8'd223: k = 8'd142;
				8'd227: k = 8'd143;
				8'd229: k = 8'd217;
				8'd230: k = 8'd156;
				8'd231: k = 8'd173;
				8'd232: k = 8'd128;
				8'd233: k = 8'd159;
				8'd234: k = 8'd158;
				8'd235: k = 8'd157;
				8'd236: k = 8'd155;
				8'd237: k = 8'd226;
				8'd239: k = 8'd112;
				default: k = ROM_UNKNOWN;
			endcase
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/atsk_front.sv =====
// ----------------------------------------------------------------------------
// atsk_front - byte decoder
// Tracks prefixes and the ambiguous-byte flags, drops prefix and control
// bytes, forms the scan index and looks up the keycode. Pushes one command
// word into the queue for each byte that produces events.
// ----------------------------------------------------------------------------
`default_nettype none

module atsk_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [7:0]          raw_byte,
	input  wire                 q_full,
	output logic                push,
	output atsk_pkg::cmd_t      push_cmd
);
	import atsk_pkg::*;

	logic [1:0]         prefix_q;
	logic [NUM_AMB-1:0] flags_q;

	logic       accept;
	logic       split;
	logic       masked;
	logic       rel;
	logic [7:0] code;
	logic       is_e0;
	logic       is_e1;
	logic       is_ctrl;
	logic [8:0] idx;
	logic [7:0] rom_key;
	logic [1:0] prefix_dec;
	logic       emit;

	// Stall only while the queue has no room
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// Classify the byte
	always_comb begin
		split = 1'b1;
		if (raw_byte == BYTE_E0 || raw_byte == BYTE_E1) begin
			split = 1'b0;
		end else begin
			for (int i = 0; i < NUM_AMB; i++) begin
				if (raw_byte == AMB_BYTES[i])
					split = flags_q[i];
			end
		end
		masked = (prefix_q != PFX_NONE) || split;
		rel    = masked && raw_byte[7];
		code   = masked ? {1'b0, raw_byte[6:0]} : raw_byte;
	end

	assign is_e0   = (code == BYTE_E0);
	assign is_e1   = (code == BYTE_E1);
	assign is_ctrl = (code == BYTE_AA) || (code == BYTE_F0) || (code == BYTE_FA) ||
	                 (code == BYTE_FE) || (code == BYTE_FF);

	// Form scan index and look up keycode
	assign idx        = {code[7], (prefix_q == PFX_E0), code[6:0]};
	assign rom_key    = rom_lookup(idx);
	assign prefix_dec = (prefix_q == PFX_NONE) ? PFX_NONE : prefix_q - 2'd1;

	assign emit = !is_e0 && !is_e1 && !is_ctrl && (prefix_dec == PFX_NONE) &&
	              (rom_key != ROM_IGNORE);

	assign push              = accept && emit;
	assign push_cmd.idx      = idx;
	assign push_cmd.key      = KEY_W'(rom_key);
	assign push_cmd.rel      = rel;

	// Advance prefix depth and ambiguous-byte flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PFX_NONE;
			flags_q  <= '0;
		end else if (accept) begin
			if (is_e0)
				prefix_q <= PFX_E0;
			else if (is_e1)
				prefix_q <= PFX_E1;
			else if (!is_ctrl)
				prefix_q <= prefix_dec;
			if (prefix_q == PFX_NONE) begin
				for (int i = 0; i < NUM_AMB; i++) begin
					if (raw_byte[6:0] == AMB_BYTES[i][6:0])
						flags_q[i] <= !raw_byte[7];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/atsk_queue.sv =====
// ----------------------------------------------------------------------------
// atsk_queue - command queue
// Short register queue that decouples the byte decoder from the event
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module atsk_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  atsk_pkg::cmd_t      push_cmd,
	output logic                full,
	output logic                q_valid,
	input  wire                 pop,
	output atsk_pkg::cmd_t      head
);
	import atsk_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];

	// Store pushed word
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Check fill bounds
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== rtl/atsk_back.sv =====
// ----------------------------------------------------------------------------
// atsk_back - event sequencer
// Steps through the scan, key and sync events of each queued word, keeps the
// pressed-key map and drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module atsk_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	input  atsk_pkg::cmd_t      head,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [1:0]          event_kind,
	output logic [8:0]          event_code,
	output logic [1:0]          event_value,
	output logic                last
);
	import atsk_pkg::*;

	step_t                    step_q;
	step_t                    step_d;
	logic [KEYCODE_SPACE-1:0] pressed_q;
	logic                     extra_q;
	logic                     ov_q;
	logic [1:0]               kind_q;
	logic [8:0]               code_q;
	logic [1:0]               value_q;
	logic                     last_q;

	logic       out_free;
	logic       fire;
	logic       unknown;
	logic       hanja;
	logic [1:0] value_now;
	logic [1:0] kind_d;
	logic [8:0] code_d;
	logic [1:0] value_d;
	logic       last_d;
	logic       extra_d;

	assign out_free = !ov_q || !out_stall;
	assign fire     = q_valid && out_free;
	assign unknown  = (head.key == KEY_W'(ROM_UNKNOWN));
	assign hanja    = (head.idx == IDX_HANJA) || (head.idx == IDX_HANGEUL);

	always_comb begin
		if (head.rel)
			value_now = VAL_RELEASE;
		else if (pressed_q[head.key])
			value_now = VAL_REPEAT;
		else
			value_now = VAL_PRESS;
	end

	// Next step and event word
	always_comb begin
		step_d  = step_q;
		kind_d  = KIND_SCAN;
		code_d  = '0;
		value_d = VAL_RELEASE;
		last_d  = 1'b0;
		extra_d = extra_q;
		pop     = 1'b0;
		unique case (step_q)
			ST_SCAN: begin
				code_d = head.idx;
				if (fire)
					step_d = unknown ? ST_SYNC : ST_KEY;
			end
			ST_KEY: begin
				kind_d  = KIND_KEY;
				code_d  = 9'(head.key);
				value_d = value_now;
				extra_d = (value_now != VAL_RELEASE) && hanja;
				if (fire)
					step_d = ST_SYNC;
			end
			ST_SYNC: begin
				kind_d = KIND_SYNC;
				last_d = unknown || !extra_q;
				pop    = fire && last_d;
				if (fire)
					step_d = last_d ? ST_SCAN : ST_SCAN2;
			end
			ST_SCAN2: begin
				code_d = head.idx;
				if (fire)
					step_d = ST_KEY2;
			end
			ST_KEY2: begin
				kind_d = KIND_KEY;
				code_d = 9'(head.key);
				if (fire)
					step_d = ST_SYNC2;
			end
			ST_SYNC2: begin
				kind_d = KIND_SYNC;
				last_d = 1'b1;
				pop    = fire;
				if (fire)
					step_d = ST_SCAN;
			end
			default: step_d = ST_SCAN;
		endcase
	end

	// Step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= ST_SCAN;
		else
			step_q <= step_d;
	end

	// Update pressed-key map and follow-up flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
			extra_q   <= 1'b0;
		end else if (fire) begin
			if (step_q == ST_KEY) begin
				pressed_q[head.key] <= (value_now != VAL_RELEASE);
				extra_q             <= extra_d;
			end else if (step_q == ST_KEY2) begin
				pressed_q[head.key] <= 1'b0;
			end
		end
	end

	// Output register: load a new word whenever the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (out_free)
			ov_q <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q  <= kind_d;
			code_q  <= code_d;
			value_q <= value_d;
			last_q  <= last_d;
		end
	end

	assign out_valid   = ov_q;
	assign event_kind  = kind_q;
	assign event_code  = code_q;
	assign event_value = value_q;
	assign last        = last_q;

	// Check sequencing
	a_extra_only_hanja: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_SCAN2 || step_q == ST_KEY2 || step_q == ST_SYNC2) |-> extra_q)
		else $error("follow-up events without a held Hanja/Hangeul key");
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (fire && last_d && kind_d == KIND_SYNC))
		else $error("word dropped before its last event");
	a_synth_release: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && step_q == ST_KEY2) |=> !pressed_q[$past(head.key)])
		else $error("synthetic release left key pressed");

endmodule

`default_nettype wire

// ===== rtl/at_scancode_to_key_event_top.sv =====
// A byte's word is registered in the queue, then its first event in the output register.
// One byte per cycle enters a two-word queue unless full; one event per cycle leaves unless
// stalled. A byte: none, scan+sync, scan+key+sync, twice (dropped, unknown, key, Hanja/Hangeul).
// Reset (arst_n low) clears prefix depth, ambiguous-byte flags, the pressed-key
// map, the queue and the output register at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// at_scancode_to_key_event_top - translated-set keyboard byte to key events
// Decoder front end, command queue and event sequencer with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module at_scancode_to_key_event_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  raw_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  event_kind,
	output logic [8:0]  event_code,
	output logic [1:0]  event_value,
	output logic        last
);
	import atsk_pkg::*;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic q_valid;
	logic pop;
	cmd_t head;

	// Decode bytes
	atsk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.raw_byte (raw_byte),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Buffer decoded words
	atsk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.pop      (pop),
		.head     (head)
	);

	// Emit events
	atsk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.event_code  (event_code),
		.event_value (event_value),
		.last        (last)
	);

endmodule

`default_nettype wire
